FILE: rtl/ple_pkg.sv
// shared types and codes for the positional list engine
package ple_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int MODE_W       = 3;
   localparam int DATA_W       = 32;
   localparam int POS_W        = 4;
   localparam int COUNT_W      = 5;
   localparam int STATUS_W     = 2;

   typedef enum logic [MODE_W-1:0] {
      MODE_INS_AT    = 3'd0,
      MODE_INS_FRONT = 3'd1,
      MODE_INS_BACK  = 3'd2,
      MODE_REM_AT    = 3'd3,
      MODE_REM_FRONT = 3'd4,
      MODE_REM_BACK  = 3'd5,
      MODE_READ      = 3'd6,
      MODE_NONE      = 3'd7
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

endpackage

FILE: rtl/positional_list_engine_unit.sv
// positional list engine top level: command decode, cell row and result register
// the result strobe rises in the cycle after the transfer of a command
// throughput: one command per cycle, and no operation stalls
// the whole row of cells shifts in parallel on insert and remove
// busy is held low; the receiver cannot stall results
// reset clears the entry count and the result strobe; entry contents stay undefined
module positional_list_engine_unit #(
   parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [ple_pkg::MODE_W-1:0]   req_mode,
   input  logic [ple_pkg::DATA_W-1:0]   req_data_in,
   input  logic [ple_pkg::POS_W-1:0]    req_position,
   output logic                         rsp_valid,
   output logic [ple_pkg::DATA_W-1:0]   rsp_data_out,
   output logic [ple_pkg::COUNT_W-1:0]  rsp_entry_count,
   output logic [ple_pkg::STATUS_W-1:0] rsp_status
);
   import ple_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              rsp_valid_ff;
   logic [DATA_W-1:0] rsp_data_ff;
   logic [DATA_W-1:0] rsp_data_in;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic [COUNT_W-1:0] rsp_count_in;
   status_type        rsp_status_ff;
   status_type        status;

   logic              accept;
   mode_type          mode;
   logic [CMP_W-1:0]  count_ext;
   logic [CMP_W-1:0]  pos_ext;
   logic [CMP_W-1:0]  at_pos;
   logic              is_insert;
   logic              is_remove;
   logic              is_read;
   logic              full;
   logic              empty;
   logic              insert_en;
   logic              remove_en;
   logic [DATA_W-1:0] sel_data;
   logic [CNT_W+COUNT_W-1:0] count_wide;

   logic [DATA_W-1:0] cell_q [CAPACITY];

   assign busy      = 1'b0;
   assign accept    = start && !busy;
   assign mode      = mode_type'(req_mode);
   assign count_ext = CMP_W'(count_ff);
   assign pos_ext   = CMP_W'(req_position);
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign empty     = (count_ff == '0);

   always_comb begin
      at_pos    = pos_ext;
      is_insert = 1'b0;
      is_remove = 1'b0;
      is_read   = 1'b0;
      unique case (mode)
         MODE_INS_AT: begin
            is_insert = 1'b1;
         end
         MODE_INS_FRONT: begin
            is_insert = 1'b1;
            at_pos    = '0;
         end
         MODE_INS_BACK: begin
            is_insert = 1'b1;
            at_pos    = count_ext;
         end
         MODE_REM_AT: begin
            is_remove = 1'b1;
         end
         MODE_REM_FRONT: begin
            is_remove = 1'b1;
            at_pos    = '0;
         end
         MODE_REM_BACK: begin
            is_remove = 1'b1;
            at_pos    = CMP_W'(count_ext - 1'b1);
         end
         MODE_READ: begin
            is_read = 1'b1;
         end
         MODE_NONE: begin
            at_pos = pos_ext;
         end
         default: begin
            at_pos = pos_ext;
         end
      endcase
   end

   // empty is checked before the position for remove and read
   always_comb begin
      status = ST_OK;
      if (is_insert) begin
         priority if (full) begin
            status = ST_FULL;
         end else if (at_pos > count_ext) begin
            status = ST_RANGE;
         end
      end else if (is_remove || is_read) begin
         priority if (empty) begin
            status = ST_EMPTY;
         end else if (at_pos >= count_ext) begin
            status = ST_RANGE;
         end
      end
   end

   assign insert_en = accept && is_insert && (status == ST_OK);
   assign remove_en = accept && is_remove && (status == ST_OK);

   always_comb begin
      sel_data = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (at_pos == CMP_W'(i)) begin
            sel_data = cell_q[i];
         end
      end
   end

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         logic [DATA_W-1:0] left_d;
         logic [DATA_W-1:0] right_d;
         if (g == 0) begin : g_first
            assign left_d = req_data_in;
         end else begin : g_mid_l
            assign left_d = cell_q[g-1];
         end
         // the top cell keeps its value when the row shifts down
         if (g == CAPACITY - 1) begin : g_last
            assign right_d = cell_q[g];
         end else begin : g_mid_r
            assign right_d = cell_q[g+1];
         end
         ple_cell #(
            .INDEX (g),
            .IDX_W (CMP_W)
         ) u_cell (
            .clock      (clock),
            .insert_en  (insert_en),
            .remove_en  (remove_en),
            .at_pos     (at_pos),
            .data_in    (req_data_in),
            .left_data  (left_d),
            .right_data (right_d),
            .cell_data  (cell_q[g])
         );
      end
   endgenerate

   always_comb begin
      count_in = count_ff;
      priority if (insert_en) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (remove_en) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
      count_wide   = {{COUNT_W{1'b0}}, count_in};
      rsp_count_in = count_wide[COUNT_W-1:0];
      rsp_data_in  = ((is_remove || is_read) && (status == ST_OK)) ? sel_data : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_status_ff <= status;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data_out    = rsp_data_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_status      = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_err_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != ST_OK) && !$past(reset)) |-> $stable(count_ff))
      else $error("failed command changed the entry count");

   a_count_needs_transfer: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff))) |-> rsp_valid_ff)
      else $error("entry count changed without a command");

   a_err_zero_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != ST_OK)) |-> (rsp_data_ff == '0))
      else $error("failed command returned data");

endmodule

FILE: rtl/ple_cell.sv
// one list entry: holds, loads, or takes a neighbor's value on a shift
module ple_cell #(
   parameter int INDEX = 0,
   parameter int IDX_W = 5
) (
   input  logic                       clock,
   input  logic                       insert_en,
   input  logic                       remove_en,
   input  logic [IDX_W-1:0]           at_pos,
   input  logic [ple_pkg::DATA_W-1:0] data_in,
   input  logic [ple_pkg::DATA_W-1:0] left_data,
   input  logic [ple_pkg::DATA_W-1:0] right_data,
   output logic [ple_pkg::DATA_W-1:0] cell_data
);
   import ple_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic [DATA_W-1:0] entry_ff;
   logic [DATA_W-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      priority if (insert_en && (MY_IDX == at_pos)) begin
         entry_in = data_in;
      end else if (insert_en && (MY_IDX > at_pos)) begin
         entry_in = left_data;
      end else if (remove_en && (MY_IDX >= at_pos)) begin
         entry_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign cell_data = entry_ff;

endmodule

FILE: verif/positional_list_engine_unit_test.sv
// testbench for the positional list engine: shadow list, command driver and result checker
`timescale 1ns / 1ps

import ple_pkg::*;

typedef struct {
   logic [DATA_W-1:0]   data_out;
   logic [COUNT_W-1:0]  entry_count;
   status_type          status;
} list_result_type;

class list_shadow;
   logic [DATA_W-1:0] cells [CAPACITY_DEF];
   int unsigned       held;
   list_result_type   awaited_results [$];
   int unsigned       mismatch_count;

   function new();
      held = 0;
      mismatch_count = 0;
   endfunction

   // apply one command to the shadow list and queue the result it should give
   function void note_command(mode_type mode, logic [DATA_W-1:0] value,
                              logic [POS_W-1:0] pos);
      list_result_type r;
      int unsigned     at;
      int              i;
      r.data_out = '0;
      r.status = ST_OK;
      case (mode)
         MODE_INS_AT, MODE_INS_FRONT, MODE_INS_BACK: begin
            at = (mode == MODE_INS_AT) ? pos : (mode == MODE_INS_FRONT) ? 0 : held;
            if (held >= CAPACITY_DEF) begin
               r.status = ST_FULL;
            end else if (at > held) begin
               r.status = ST_RANGE;
            end else begin
               for (i = held; i > at; i--) cells[i] = cells[i-1];
               cells[at] = value;
               held++;
            end
         end
         MODE_REM_AT, MODE_REM_FRONT, MODE_REM_BACK: begin
            if (held == 0) begin
               r.status = ST_EMPTY;
            end else begin
               at = (mode == MODE_REM_AT) ? pos : (mode == MODE_REM_FRONT) ? 0 : held - 1;
               if (at >= held) begin
                  r.status = ST_RANGE;
               end else begin
                  r.data_out = cells[at];
                  held--;
                  for (i = at; i < held; i++) cells[i] = cells[i+1];
               end
            end
         end
         MODE_READ: begin
            if (held == 0) r.status = ST_EMPTY;
            else if (pos >= held) r.status = ST_RANGE;
            else r.data_out = cells[pos];
         end
         default: begin
         end
      endcase
      r.entry_count = held[COUNT_W-1:0];
      awaited_results.push_back(r);
   endfunction

   function void check_result(logic [DATA_W-1:0] data, logic [COUNT_W-1:0] count,
                              logic [STATUS_W-1:0] status);
      list_result_type e;
      if (awaited_results.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("result with no command waiting: data %h count %0d status %0d",
                     data, count, status);
         return;
      end
      e = awaited_results.pop_front();
      if (data !== e.data_out || count !== e.entry_count || status !== e.status) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("expected data %h count %0d status %0d, got data %h count %0d status %0d",
                     e.data_out, e.entry_count, e.status, data, count, status);
      end
   endfunction
endclass

module positional_list_engine_unit_test;

   localparam int CYCLE_LIMIT = 200000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [MODE_W-1:0]   req_mode = '0;
   logic [DATA_W-1:0]   req_data_in = '0;
   logic [POS_W-1:0]    req_position = '0;
   logic                rsp_valid;
   logic [DATA_W-1:0]   rsp_data_out;
   logic [COUNT_W-1:0]  rsp_entry_count;
   logic [STATUS_W-1:0] rsp_status;

   int unsigned cycle_count = 0;
   list_shadow  shadow = new();

   positional_list_engine_unit uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_mode(req_mode),
      .req_data_in(req_data_in),
      .req_position(req_position),
      .rsp_valid(rsp_valid),
      .rsp_data_out(rsp_data_out),
      .rsp_entry_count(rsp_entry_count),
      .rsp_status(rsp_status)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("positional_list_engine_unit: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid !== 1'b0)
         shadow.check_result(rsp_data_out, rsp_entry_count, rsp_status);
   end

   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(11))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // entered and left at a falling edge; start stays high across back-to-back commands
   task automatic send_command(mode_type mode, logic [DATA_W-1:0] value,
                               logic [POS_W-1:0] pos, int unsigned idle_pct);
      req_mode = mode;
      req_data_in = value;
      req_position = pos;
      start = 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      shadow.note_command(mode, value, pos);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
   endtask

   task automatic random_commands(int unsigned n, int unsigned idle_pct);
      int unsigned lean;
      mode_type    mode;
      logic [POS_W-1:0] pos;
      for (int k = 0; k < n; k++) begin
         // drift between draining, balanced and filling stretches
         if (k % 64 == 0) lean = $urandom_range(2) * 30 + 20;
         pos = POS_W'($urandom_range(15));
         if ($urandom_range(99) < 12) begin
            mode = mode_type'($urandom_range(7));
         end else if ($urandom_range(99) < lean) begin
            mode = mode_type'($urandom_range(2));
            if (shadow.held < CAPACITY_DEF) pos = POS_W'($urandom_range(shadow.held));
         end else begin
            mode = mode_type'($urandom_range(6, 3));
            if (shadow.held != 0) pos = POS_W'($urandom_range(shadow.held - 1));
         end
         send_command(mode, pick_value(), pos, idle_pct);
      end
   endtask

   initial begin
      repeat (7) @(negedge clock);
      reset = 1'b0;

      // empty list: empty status wins over a bad position
      send_command(MODE_READ, 32'h1234_5678, 4'd0, 15);
      send_command(MODE_REM_AT, 32'h0, 4'd3, 15);
      send_command(MODE_REM_FRONT, 32'h0, 4'd0, 15);
      send_command(MODE_REM_BACK, 32'h0, 4'd15, 15);
      send_command(MODE_INS_AT, 32'h5555_aaaa, 4'd5, 15);
      send_command(MODE_INS_AT, 32'h7fff_ffff, 4'd0, 15);
      send_command(MODE_INS_FRONT, 32'h8000_0000, 4'd0, 15);
      send_command(MODE_INS_BACK, 32'h0000_0000, 4'd9, 15);
      send_command(MODE_INS_BACK, 32'hffff_ffff, 4'd0, 15);
      send_command(MODE_NONE, 32'hdead_beef, 4'd1, 15);
      send_command(MODE_READ, 32'h0, 4'd4, 15);
      send_command(MODE_REM_AT, 32'h0, 4'd4, 15);
      // position equal to the count appends
      send_command(MODE_INS_AT, 32'h0bad_cafe, 4'd4, 15);
      while (shadow.held < CAPACITY_DEF)
         send_command(MODE_INS_AT, pick_value(), POS_W'($urandom_range(shadow.held)), 15);
      send_command(MODE_INS_FRONT, 32'h1111_1111, 4'd0, 15);
      send_command(MODE_READ, 32'h0, 4'd15, 15);
      send_command(MODE_REM_AT, 32'h0, 4'd15, 15);

      random_commands(580, 15);
      random_commands(580, 65);
      random_commands(580, 0);
      start = 1'b0;

      while (shadow.awaited_results.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (shadow.mismatch_count == 0 && shadow.awaited_results.size() == 0) begin
         $display("positional_list_engine_unit: match");
      end else begin
         $display("positional_list_engine_unit: mismatch");
      end
      $finish;
   end

endmodule
